### hw/rtl/nbc_pkg.sv
// Shared types, codes and constants of the network-boot sequencer.
package nbc_pkg;

    // Default data block size of the file transfer
    localparam int BLOCK_BYTES_DEF = 512;

    // Results one input word can cause, and depth of the result queue
    localparam int RES_MAX    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_PW + 1;

    // Protocol constants
    localparam logic [15:0] BOOTP_MIN_SIZE = 16'd300;
    localparam logic [7:0]  BOOTP_REPLY_OP = 8'd2;
    localparam logic [15:0] TFTP_OP_DATA   = 16'd3;
    localparam logic [15:0] TFTP_OP_ERROR  = 16'd5;

    // Register reset values
    localparam logic [31:0] XID_RESET           = 32'h1234_5678;
    localparam logic [15:0] SERVER_PORT_RESET   = 16'd67;
    localparam logic [3:0]  ATTEMPT_LIMIT_RESET = 4'd5;
    localparam logic [3:0]  ATTEMPT_LIMIT_MAX   = 4'd8;

    // Input word kinds
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TICK   = 2'd1,
        OP_PACKET = 2'd2
    } t_opcode;

    // Result actions
    typedef enum logic [2:0] {
        ACT_BOOTP  = 3'd0,
        ACT_RRQ    = 3'd1,
        ACT_ACK    = 3'd2,
        ACT_PROG   = 3'd3,
        ACT_RESEND = 3'd4,
        ACT_OK     = 3'd5,
        ACT_FAIL   = 3'd6
    } t_action;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_XID   = 2'd0,
        CFG_PORT  = 2'd1,
        CFG_LIMIT = 2'd2
    } t_cfg_idx;

    // Sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_BOOTP  = 5'b00010,
        PH_TFTP   = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAILED = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] src_port;
        logic [15:0] udp_size;
        logic [15:0] head_word0;
        logic [15:0] head_word1;
        logic [31:0] head_xid;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [15:0] block_number;
        logic [15:0] flash_address;
        logic [9:0]  data_length;
        logic [15:0] peer_port;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] transaction_id;
        logic [15:0] server_port;
        logic [3:0]  attempt_limit;
    } t_cfg_regs;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  attempt_index;
        logic [7:0]  ticks_left;
        logic [15:0] expected_block;
        logic [15:0] learned_port;
    } t_state;

    // Queue status toward the input stage
    typedef struct packed {
        logic               space_ok;
        logic [FIFO_CW-1:0] count;
    } t_fifo_stat;

endpackage

### hw/rtl/nbc_chan_if.sv
// Valid/ready channel carrying one payload word.
interface nbc_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/nbc_step.sv
// Decision logic: next sequencer state and result words for one input word.
module nbc_step #(
    parameter int BLOCK_BYTES = nbc_pkg::BLOCK_BYTES_DEF
) (
    input  nbc_pkg::t_item                    i_item,
    input  nbc_pkg::t_cfg_regs                i_cfg,
    input  nbc_pkg::t_state                   i_state,
    output nbc_pkg::t_state                   o_state,
    output nbc_pkg::t_res [nbc_pkg::RES_MAX-1:0] o_res,
    output logic [1:0]                        o_res_cnt
);
    import nbc_pkg::*;

    localparam logic [15:0] BB16   = 16'(BLOCK_BYTES);
    localparam logic [15:0] BB_P4  = 16'(BLOCK_BYTES + 4);

    logic [4:0]  eff_limit;
    logic [4:0]  ai_p1;
    logic [7:0]  ticks_dec;
    logic [16:0] blk_p1;
    logic [15:0] blk_m1;
    logic [15:0] prog_addr;
    logic [15:0] raw_len;
    logic [15:0] clip_len;
    logic        bootp_ok;
    logic        in_wait;

    function automatic t_res mk_res(t_action act, logic [15:0] blk, logic lst);
        t_res r;
        r               = '0;
        r.action        = act;
        r.block_number  = blk;
        r.last          = lst;
        return r;
    endfunction

    // Operand prep
    always_comb begin
        if (i_cfg.attempt_limit == 4'd0) begin
            eff_limit = 5'd1;
        end else if (i_cfg.attempt_limit > ATTEMPT_LIMIT_MAX) begin
            eff_limit = {1'b0, ATTEMPT_LIMIT_MAX};
        end else begin
            eff_limit = {1'b0, i_cfg.attempt_limit};
        end
        ai_p1     = {1'b0, i_state.attempt_index} + 5'd1;
        ticks_dec = (i_state.ticks_left != 8'd0) ? i_state.ticks_left - 8'd1 : 8'd0;
        blk_p1    = {1'b0, i_state.expected_block} + 17'd1;
        blk_m1    = i_item.head_word1 - 16'd1;
        prog_addr = 16'(blk_m1 * BB16);
        raw_len   = (i_item.udp_size < 16'd4) ? 16'd0 : i_item.udp_size - 16'd4;
        clip_len  = (raw_len > BB16) ? BB16 : raw_len;
        bootp_ok  = (i_item.src_port == i_cfg.server_port) &&
                    (i_item.udp_size >= BOOTP_MIN_SIZE) &&
                    (i_item.head_word0[15:8] == BOOTP_REPLY_OP) &&
                    (i_item.head_xid == i_cfg.transaction_id);
        in_wait   = (i_state.phase == PH_BOOTP) || (i_state.phase == PH_TFTP);
    end

    // Sequencer decision
    always_comb begin
        o_state   = i_state;
        o_res     = '0;
        o_res_cnt = 2'd0;
        case (i_item.opcode)
            OP_START: begin
                o_state.phase          = PH_BOOTP;
                o_state.expected_block = 16'd0;
                o_state.learned_port   = 16'd0;
                o_state.attempt_index  = 4'd0;
                o_state.ticks_left     = 8'd1;
                o_res[0]               = mk_res(ACT_BOOTP, 16'd0, 1'b1);
                o_res_cnt              = 2'd1;
            end
            OP_TICK: begin
                if (in_wait) begin
                    o_state.ticks_left = ticks_dec;
                    if (ticks_dec == 8'd0) begin
                        o_res_cnt = 2'd1;
                        if (ai_p1 < eff_limit) begin
                            o_state.attempt_index = ai_p1[3:0];
                            o_state.ticks_left    = 8'd1 << ai_p1[2:0];
                            o_res[0] = mk_res(ACT_RESEND, i_state.expected_block, 1'b1);
                        end else begin
                            o_state.phase = PH_FAILED;
                            o_res[0] = mk_res(ACT_FAIL, i_state.expected_block, 1'b1);
                        end
                    end
                end
            end
            OP_PACKET: begin
                if (i_state.phase == PH_BOOTP) begin
                    if (bootp_ok) begin
                        o_state.phase          = PH_TFTP;
                        o_state.expected_block = 16'd0;
                        o_state.attempt_index  = 4'd0;
                        o_state.ticks_left     = 8'd1;
                        o_res[0]               = mk_res(ACT_RRQ, 16'd0, 1'b1);
                        o_res_cnt              = 2'd1;
                    end
                end else if (i_state.phase == PH_TFTP) begin
                    if (i_item.head_word0 == TFTP_OP_ERROR) begin
                        o_state.phase = PH_FAILED;
                        o_res[0]  = mk_res(ACT_FAIL, i_state.expected_block, 1'b1);
                        o_res_cnt = 2'd1;
                    end else if ((i_item.head_word0 == TFTP_OP_DATA) &&
                                 ({1'b0, i_item.head_word1} == blk_p1)) begin
                        // in-order data block: program, then ack
                        if (i_state.expected_block == 16'd0) begin
                            o_state.learned_port = i_item.src_port;
                        end
                        o_state.expected_block = i_item.head_word1;
                        o_res[0] = mk_res(ACT_PROG, i_item.head_word1, 1'b0);
                        o_res[0].flash_address = prog_addr;
                        o_res[0].data_length   = clip_len[9:0];
                        if (i_item.udp_size == BB_P4) begin
                            o_state.attempt_index = 4'd0;
                            o_state.ticks_left    = 8'd1;
                            o_res[1]  = mk_res(ACT_ACK, i_item.head_word1, 1'b1);
                            o_res_cnt = 2'd2;
                        end else begin
                            // short or oversized block ends the transfer
                            o_state.phase = PH_DONE;
                            o_res[1]  = mk_res(ACT_ACK, i_item.head_word1, 1'b0);
                            o_res[2]  = mk_res(ACT_OK, i_item.head_word1, 1'b1);
                            o_res_cnt = 2'd3;
                        end
                    end
                end
            end
            default: begin
                o_res_cnt = 2'd0;
            end
        endcase
        // every result carries the peer port as updated by this word
        for (int k = 0; k < RES_MAX; k++) begin
            o_res[k].peer_port = o_state.learned_port;
        end
    end

endmodule

### hw/rtl/nbc_res_fifo.sv
// Result queue: takes up to three words per cycle, hands out one per cycle while the receiver is ready.
module nbc_res_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [1:0]                        i_push_cnt,
    input  nbc_pkg::t_res [nbc_pkg::RES_MAX-1:0] i_push_data,
    output nbc_pkg::t_fifo_stat               o_stat,
    nbc_chan_if.source                        o_res
);
    import nbc_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wr_ptr;
    logic [FIFO_PW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_CW-1:0] n_count;
    logic [FIFO_CW-1:0] left;
    logic               pop;

    // Output side
    assign o_res.valid = (r_count != '0);
    assign o_res.data  = r_mem[r_rd_ptr];
    assign pop         = o_res.valid & o_res.ready;

    // Room for a full burst once this cycle's pop is counted
    assign left            = r_count - FIFO_CW'(pop);
    assign o_stat.space_ok = (left <= FIFO_CW'(FIFO_DEPTH - RES_MAX));
    assign o_stat.count    = r_count;
    assign n_count         = left + FIFO_CW'(i_push_cnt);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PW'(i_push_cnt);
            r_rd_ptr <= r_rd_ptr + FIFO_PW'(pop);
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (k < int'(i_push_cnt)) begin
                r_mem[r_wr_ptr + FIFO_PW'(k)] <= i_push_data[k];
            end
        end
    end

endmodule

### hw/rtl/netboot_bootp_tftp_client.sv
// Top level of the network-boot sequencer: input stage, state, config and result queue.
// An input word (start, timer tick or received packet header) is registered, decided from
// the input register and its results, zero to three, enter a four-word result queue, from
// which the first result is offered once written. Results leave one per cycle while the
// receiver is ready. A new word is taken every cycle as long as each word gives
// at most one result and results are taken as offered; otherwise a word waits in the input
// register while the queue, less the word leaving this cycle, holds more than one word, so
// throughput is bound by the single result port of the queue. Configuration writes are
// always taken and apply to words decided afterwards; unknown indexes are dropped.
module netboot_bootp_tftp_client #(
    parameter int BLOCK_BYTES = nbc_pkg::BLOCK_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nbc_chan_if.sink   i_item,
    nbc_chan_if.sink   i_cfg,
    nbc_chan_if.source o_res
);
    import nbc_pkg::*;

    logic                 r_in_valid;
    t_item                r_in;
    t_cfg_regs            r_cfg;
    t_state               r_state;
    t_state               n_state;
    t_res [RES_MAX-1:0]   step_res;
    logic [1:0]           step_cnt;
    t_fifo_stat           fifo_stat;
    logic                 proc_fire;
    logic [1:0]           push_cnt;
    t_cfg_wr              cfg_wr;

    assign proc_fire    = r_in_valid & fifo_stat.space_ok;
    assign push_cnt     = proc_fire ? step_cnt : 2'd0;
    assign i_item.ready = ~r_in_valid | proc_fire;
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr       = i_cfg.data;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transaction_id <= XID_RESET;
            r_cfg.server_port    <= SERVER_PORT_RESET;
            r_cfg.attempt_limit  <= ATTEMPT_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (cfg_wr.index)
                CFG_XID:   r_cfg.transaction_id <= cfg_wr.value;
                CFG_PORT:  r_cfg.server_port    <= cfg_wr.value[15:0];
                CFG_LIMIT: r_cfg.attempt_limit  <= cfg_wr.value[3:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.attempt_index  <= 4'd0;
            r_state.ticks_left     <= 8'd0;
            r_state.expected_block <= 16'd0;
            r_state.learned_port   <= 16'd0;
        end else if (proc_fire) begin
            r_state <= n_state;
        end
    end

    nbc_step #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_step (
        .i_item    (r_in),
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_res     (step_res),
        .o_res_cnt (step_cnt)
    );

    nbc_res_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push_data (step_res),
        .o_stat      (fifo_stat),
        .o_res       (o_res)
    );

    // Queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // A waiting phase always has a live retry timer
    a_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_BOOTP || r_state.phase == PH_TFTP) |-> r_state.ticks_left != 8'd0)
        else $error("retry timer expired in a wait phase");

    // A stalled input word is held, not dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |=> (r_in_valid && $stable(r_in)))
        else $error("pending input word lost");

    // Success is always the closing word of its run
    a_ok_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.action == ACT_OK) |-> o_res.data.last)
        else $error("success result not marked last");

endmodule

### verif/netboot_bootp_tftp_client_tb.sv
// Testbench of the network-boot sequencer: directed and random boot runs checked by a predictor.
module netboot_bootp_tftp_client_tb;
    import nbc_pkg::*;

    localparam int          BLOCK_SIZE   = BLOCK_BYTES_DEF;
    localparam logic [15:0] FULL_SIZE    = 16'(BLOCK_BYTES_DEF + 4);
    localparam logic [1:0]  OP_UNKNOWN   = 2'd3;
    localparam logic [15:0] TFTP_OP_ACKN = 16'd4;
    localparam int          IDLE_PCT     = 31;
    localparam int          RANDOM_WORDS = 100;
    localparam int          WRAP_BLOCKS  = 130;
    localparam int          SETTLE_CYC   = 8;
    localparam int          MAX_CYCLES   = 1_000_000;
    localparam int          MAX_REPORTS  = 60;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nbc_chan_if #(.T(t_item))   item_if ();
    nbc_chan_if #(.T(t_cfg_wr)) cfg_if ();
    nbc_chan_if #(.T(t_res))    res_if ();

    netboot_bootp_tftp_client i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor copy of registers and sequencer state
    logic [31:0] xid_reg   = XID_RESET;
    logic [15:0] port_reg  = SERVER_PORT_RESET;
    logic [3:0]  limit_reg = ATTEMPT_LIMIT_RESET;
    t_phase      boot_phase     = PH_IDLE;
    logic [3:0]  attempt_idx    = '0;
    logic [7:0]  backoff_ticks  = '0;
    logic [15:0] next_block_exp = '0;
    logic [15:0] peer_learned   = '0;

    t_res pending_actions[$];
    int   errors       = 0;
    int   words_sent   = 0;
    int   actions_seen = 0;
    int   idle_pct     = IDLE_PCT;

    always #2 i_clk = ~i_clk;

    // Receiver backpressure
    always @(negedge i_clk) begin
        res_if.ready <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
    end

    // Run limit
    initial begin
        #(MAX_CYCLES * 4);
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (errors < MAX_REPORTS) begin
            $display("MISMATCH: %s", msg);
        end
        errors++;
    endtask

    function automatic t_res make_action(t_action act, logic [15:0] blk, logic [15:0] addr,
                                         logic [9:0] len, logic lst);
        t_res r;
        r.action        = act;
        r.block_number  = blk;
        r.flash_address = addr;
        r.data_length   = len;
        r.peer_port     = peer_learned;
        r.last          = lst;
        return r;
    endfunction

    function automatic t_item make_word(logic [1:0] op, logic [15:0] sport, logic [15:0] size,
                                        logic [15:0] w0, logic [15:0] w1, logic [31:0] xid);
        t_item w;
        w.opcode     = op;
        w.src_port   = sport;
        w.udp_size   = size;
        w.head_word0 = w0;
        w.head_word1 = w1;
        w.head_xid   = xid;
        return w;
    endfunction

    // Work out the actions one accepted word causes
    task automatic predict_actions(input t_item it);
        logic [3:0]  lim;
        logic [15:0] addr;
        logic [16:0] len;
        lim = (limit_reg == 4'd0) ? 4'd1 :
              (limit_reg > ATTEMPT_LIMIT_MAX) ? ATTEMPT_LIMIT_MAX : limit_reg;
        case (it.opcode)
            OP_START: begin
                boot_phase     = PH_BOOTP;
                next_block_exp = '0;
                peer_learned   = '0;
                attempt_idx    = '0;
                backoff_ticks  = 8'd1;
                pending_actions.push_back(make_action(ACT_BOOTP, '0, '0, '0, 1'b1));
            end
            OP_TICK: begin
                if (boot_phase == PH_BOOTP || boot_phase == PH_TFTP) begin
                    if (backoff_ticks != 8'd0) backoff_ticks--;
                    if (backoff_ticks == 8'd0) begin
                        if ({1'b0, attempt_idx} + 5'd1 < {1'b0, lim}) begin
                            attempt_idx++;
                            backoff_ticks = 8'd1 << attempt_idx[2:0];
                            pending_actions.push_back(
                                make_action(ACT_RESEND, next_block_exp, '0, '0, 1'b1));
                        end else begin
                            boot_phase = PH_FAILED;
                            pending_actions.push_back(
                                make_action(ACT_FAIL, next_block_exp, '0, '0, 1'b1));
                        end
                    end
                end
            end
            OP_PACKET: begin
                if (boot_phase == PH_BOOTP) begin
                    if (it.src_port == port_reg && it.udp_size >= BOOTP_MIN_SIZE &&
                        it.head_word0[15:8] == BOOTP_REPLY_OP && it.head_xid == xid_reg) begin
                        boot_phase     = PH_TFTP;
                        next_block_exp = '0;
                        attempt_idx    = '0;
                        backoff_ticks  = 8'd1;
                        pending_actions.push_back(make_action(ACT_RRQ, '0, '0, '0, 1'b1));
                    end
                end else if (boot_phase == PH_TFTP) begin
                    if (it.head_word0 == TFTP_OP_ERROR) begin
                        boot_phase = PH_FAILED;
                        pending_actions.push_back(
                            make_action(ACT_FAIL, next_block_exp, '0, '0, 1'b1));
                    end else if (it.head_word0 == TFTP_OP_DATA &&
                                 {1'b0, it.head_word1} == {1'b0, next_block_exp} + 17'd1) begin
                        // first block fixes the peer port
                        if (next_block_exp == 16'd0) peer_learned = it.src_port;
                        next_block_exp = it.head_word1;
                        addr = 16'((it.head_word1 - 16'd1) * BLOCK_SIZE);
                        len  = (it.udp_size < 16'd4) ? 17'd0 : {1'b0, it.udp_size} - 17'd4;
                        if (len > 17'(BLOCK_SIZE)) len = 17'(BLOCK_SIZE);
                        pending_actions.push_back(
                            make_action(ACT_PROG, it.head_word1, addr, len[9:0], 1'b0));
                        if (it.udp_size == FULL_SIZE) begin
                            attempt_idx   = '0;
                            backoff_ticks = 8'd1;
                            pending_actions.push_back(
                                make_action(ACT_ACK, it.head_word1, '0, '0, 1'b1));
                        end else begin
                            // short or oversized block ends the transfer
                            pending_actions.push_back(
                                make_action(ACT_ACK, it.head_word1, '0, '0, 1'b0));
                            boot_phase = PH_DONE;
                            pending_actions.push_back(
                                make_action(ACT_OK, it.head_word1, '0, '0, 1'b1));
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      actions_seen, name, got, want));
        end
    endtask

    // Compare every result word with the oldest expected action
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (pending_actions.size() == 0) begin
                report_mismatch($sformatf("result %0d not expected, action %0d",
                                          actions_seen, got.action));
            end else begin
                want = pending_actions.pop_front();
                check_field("action", 32'(got.action), 32'(want.action));
                check_field("block_number", 32'(got.block_number), 32'(want.block_number));
                check_field("flash_address", 32'(got.flash_address),
                            32'(want.flash_address));
                check_field("data_length", 32'(got.data_length), 32'(want.data_length));
                check_field("peer_port", 32'(got.peer_port), 32'(want.peer_port));
                check_field("last", 32'(got.last), 32'(want.last));
            end
            actions_seen++;
        end
    end

    // Send one input word, with a random gap ahead of it
    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
        predict_actions(it);
        words_sent++;
    endtask

    // Hold off the sender until every expected action has come out
    task automatic drain();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [31:0] val);
        t_cfg_wr wr;
        wr.index = idx;
        wr.value = val;
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= wr;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            CFG_XID:   xid_reg   = val;
            CFG_PORT:  port_reg  = val[15:0];
            CFG_LIMIT: limit_reg = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] xid, input logic [15:0] port,
                                  input logic [3:0] lim);
        drain();
        write_register(CFG_XID, xid);
        write_register(CFG_PORT, {16'h0, port});
        write_register(CFG_LIMIT, {28'h0, lim});
    endtask

    task automatic send_start();
        send_item(make_word(OP_START, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), $urandom));
    endtask

    task automatic send_tick();
        send_item(make_word(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), $urandom));
    endtask

    task automatic send_reply(input logic [15:0] size);
        send_item(make_word(OP_PACKET, port_reg, size, {BOOTP_REPLY_OP, 8'($urandom)},
                            16'($urandom), xid_reg));
    endtask

    task automatic send_data(input logic [15:0] blk, input logic [15:0] size,
                             input logic [15:0] sport);
        send_item(make_word(OP_PACKET, sport, size, TFTP_OP_DATA, blk, $urandom));
    endtask

    // Words that a healthy run mostly ignores
    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: send_tick();
            1: send_item(make_word(OP_UNKNOWN, 16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), $urandom));
            2: send_item(make_word(OP_PACKET, 16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), $urandom));
            3: send_data(16'($urandom), 16'($urandom), 16'($urandom));
            default: send_item(make_word(OP_PACKET, 16'($urandom), 16'($urandom),
                                         TFTP_OP_ACKN, 16'($urandom), $urandom));
        endcase
    endtask

    // Reply matching on reset register values
    task automatic test_register_defaults();
        send_start();
        send_item(make_word(OP_PACKET, 16'd67, 16'd300, 16'h02ff, 16'h0000, 32'h1234_5678));
    endtask

    // Each BOOTP reply check on its own, then a resend and a good reply
    task automatic test_reply_filter();
        send_start();
        send_item(make_word(OP_PACKET, port_reg ^ 16'h1, 16'hffff, 16'h0200, '0, xid_reg));
        send_item(make_word(OP_PACKET, port_reg, 16'd299, 16'h0200, '0, xid_reg));
        send_item(make_word(OP_PACKET, port_reg, 16'd300, 16'h0102, '0, xid_reg));
        send_item(make_word(OP_PACKET, port_reg, 16'd300, 16'h0200, '0, ~xid_reg));
        send_tick();
        send_reply(16'hffff);
    endtask

    // In-order blocks, ignored packets, a tiny last block, words after the end
    task automatic test_transfer();
        send_data(16'd2, 16'd516, 16'h4000);
        send_item(make_word(OP_PACKET, 16'h4000, 16'd516, TFTP_OP_ACKN, 16'd1, '0));
        send_data(16'd1, 16'd516, 16'hffff);
        send_data(16'd2, 16'd516, 16'h0000);
        send_data(16'd3, 16'd3, 16'h0000);
        send_data(16'd4, 16'd516, 16'hffff);
        send_tick();
        send_item(make_word(OP_UNKNOWN, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff));
    endtask

    task automatic test_error_packet();
        send_start();
        send_reply(16'd300);
        send_item(make_word(OP_PACKET, 16'h1234, 16'd20, TFTP_OP_ERROR, 16'd1, '0));
    endtask

    // Restart in the middle of a transfer, then an oversized block
    task automatic test_restart();
        send_start();
        send_reply(16'd300);
        send_data(16'd1, 16'd516, 16'h0045);
        send_start();
        send_reply(16'd300);
        send_data(16'd1, 16'hffff, 16'h0099);
    endtask

    task automatic test_attempt_limit();
        apply_settings(XID_RESET, SERVER_PORT_RESET, 4'd1);
        send_start();
        send_tick();
        send_tick();
    endtask

    // Random boot sessions with random content, noise and broken endings
    task automatic test_random();
        int          session;
        int          stop_at;
        int          n_blocks;
        int          k;
        int          ending;
        logic [15:0] sport;
        session = 0;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            idle_pct = (session >= 8 && session < 16) ? 0 : IDLE_PCT;
            if (session == 0) begin
                apply_settings(32'h0, 16'h0, 4'd0);
            end else if (session == 1) begin
                apply_settings(32'hffff_ffff, 16'hffff, 4'd15);
            end else if (session == 2) begin
                apply_settings($urandom, 16'($urandom), 4'd8);
            end else if ($urandom_range(0, 3) == 0) begin
                apply_settings($urandom, 16'($urandom), 4'($urandom_range(0, 15)));
            end else if ($urandom_range(0, 7) == 0) begin
                drain();
            end
            send_start();
            repeat ($urandom_range(0, 3)) send_noise();
            if ($urandom_range(0, 99) < 85) begin
                send_reply(16'($urandom_range(300, 65535)));
            end
            n_blocks = $urandom_range(1, 8);
            sport    = 16'($urandom);
            for (k = 1; k <= n_blocks; k++) begin
                if ($urandom_range(0, 3) == 0) send_noise();
                if (k < n_blocks) begin
                    send_data(16'(k), FULL_SIZE, sport);
                end else begin
                    ending = $urandom_range(0, 9);
                    if (ending == 0) begin
                        send_item(make_word(OP_PACKET, 16'($urandom), 16'($urandom),
                                            TFTP_OP_ERROR, 16'($urandom), $urandom));
                    end else if (ending <= 2) begin
                        send_data(16'(k), FULL_SIZE, sport);
                    end else if (ending <= 4) begin
                        send_data(16'(k), 16'($urandom_range(0, 3)), sport);
                    end else if (ending <= 7) begin
                        send_data(16'(k), 16'($urandom_range(4, BLOCK_SIZE + 3)), sport);
                    end else begin
                        send_data(16'(k), 16'($urandom_range(BLOCK_SIZE + 5, 65535)), sport);
                    end
                end
            end
            session++;
        end
        idle_pct = IDLE_PCT;
    endtask

    // Walk past the block whose program address wraps; stale and far blocks are then ignored
    task automatic test_address_wrap();
        int blk;
        drain();
        idle_pct = 0;
        send_start();
        send_reply(16'd300);
        for (blk = 1; blk <= WRAP_BLOCKS; blk++) begin
            send_data(16'(blk), FULL_SIZE, 16'h7e01);
        end
        send_data(16'd0, FULL_SIZE, 16'h7e01);
        send_data(16'hffff, FULL_SIZE, 16'h7e01);
        send_tick();
        send_item(make_word(OP_PACKET, 16'h7e01, 16'd4, TFTP_OP_ERROR, 16'd0, '0));
        idle_pct = IDLE_PCT;
    endtask

    initial begin
        item_if.valid = 1'b0;
        item_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        res_if.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();
        test_reply_filter();
        test_transfer();
        test_error_packet();
        test_restart();
        test_attempt_limit();
        test_random();
        test_address_wrap();

        drain();
        repeat (20) @(posedge i_clk);
        if (pending_actions.size() != 0) begin
            report_mismatch($sformatf("%0d expected actions never came out",
                                      pending_actions.size()));
        end
        $display("Ran %0d input words through directed cases, random boot sessions and",
                 words_sent);
        $display("a long transfer past the address wrap; %0d result words checked, %0d mismatches",
                 actions_seen, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
